// ===== src/mfp_pkg.sv =====
// meter frame parser package: layout constants, record types, status codes
// and the crc-16 byte update; used by the core, record queue, top level and checker
package mfp_pkg;

    localparam int DEF_LINE_COUNT     = 3;
    localparam int DEF_SENSOR_COUNT   = 3;
    localparam int DEF_PAYLOAD_LENGTH = 53;

    localparam int HEAD_BYTES     = 4;
    localparam int LINE_BYTES     = 16;
    localparam int FRAME_OVERHEAD = 6;
    localparam int REC_FIFO_DEPTH = 4;

    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;

    typedef enum logic [1:0] {
        KIND_LINE    = 2'd0,
        KIND_TEMP    = 2'd1,
        KIND_VERDICT = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        STATUS_OK    = 3'd0,
        STATUS_SHORT = 3'd1,
        STATUS_LONG  = 3'd2,
        STATUS_LEN   = 3'd3,
        STATUS_CRC   = 3'd4
    } status_t;

    typedef struct packed {
        kind_t       kind;
        logic [2:0]  index;
        logic [15:0] voltage_or_address;
        logic [15:0] current_or_function;
        logic [15:0] power_or_rate;
        logic [24:0] energy;
        logic [15:0] alarm_current;
        logic [7:0]  power_factor;
        logic [7:0]  switch_state;
        logic [15:0] harmonic;
        logic [28:0] apparent_power;
        status_t     status;
    } rec_t;

    typedef struct packed {
        logic first;
        logic second;
    } push_t;

    function automatic logic [15:0] crc16_feed(logic [15:0] crc_in, logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== src/mfp_byte_if.sv =====
// input channel of the meter frame parser: one frame byte per beat
// no dependencies
interface mfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_end;

    modport source (output valid, output rx_byte, output frame_end, input ready);
    modport sink (input valid, input rx_byte, input frame_end, output ready);
endinterface

// ===== src/mfp_rec_if.sv =====
// output channel of the meter frame parser: one record per beat
// no dependencies
interface mfp_rec_if;
    logic        valid;
    logic        ready;
    logic [1:0]  record_kind;
    logic [2:0]  record_index;
    logic [15:0] voltage_or_address;
    logic [15:0] current_or_function;
    logic [15:0] power_or_rate;
    logic [24:0] energy;
    logic [15:0] alarm_current;
    logic [7:0]  power_factor;
    logic [7:0]  switch_state;
    logic [15:0] harmonic;
    logic [28:0] apparent_power;
    logic [2:0]  frame_status;

    modport source (
        output valid, input ready,
        output record_kind, output record_index, output voltage_or_address,
        output current_or_function, output power_or_rate, output energy,
        output alarm_current, output power_factor, output switch_state,
        output harmonic, output apparent_power, output frame_status
    );
    modport sink (
        input valid, output ready,
        input record_kind, input record_index, input voltage_or_address,
        input current_or_function, input power_or_rate, input energy,
        input alarm_current, input power_factor, input switch_state,
        input harmonic, input apparent_power, input frame_status
    );
endinterface

// ===== src/mfp_core.sv =====
// frame parsing core: byte position, crc, field assembly and record build
// depends on mfp_pkg
module mfp_core #(
    parameter int LINE_COUNT     = mfp_pkg::DEF_LINE_COUNT,
    parameter int SENSOR_COUNT   = mfp_pkg::DEF_SENSOR_COUNT,
    parameter int PAYLOAD_LENGTH = mfp_pkg::DEF_PAYLOAD_LENGTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic [7:0]     rx_byte,
    input  logic           frame_end,
    output mfp_pkg::rec_t  rec0,
    output mfp_pkg::rec_t  rec1,
    output mfp_pkg::push_t push
);
    import mfp_pkg::*;

    localparam int FRAME_TOTAL = PAYLOAD_LENGTH + FRAME_OVERHEAD;
    localparam int RATE_INT    = HEAD_BYTES + LINE_BYTES * LINE_COUNT;
    localparam logic [7:0] CRC_LO_POS = 8'(FRAME_TOTAL - 2);
    localparam logic [7:0] LAST_POS   = 8'(FRAME_TOTAL - 1);
    localparam logic [7:0] RATE_POS   = 8'(RATE_INT);
    localparam logic [7:0] COUNT_POS  = 8'(RATE_INT + SENSOR_COUNT + 1);
    localparam logic [7:0] HEAD_POS   = 8'(HEAD_BYTES);
    localparam logic [7:0] POS_MAX    = 8'hFF;
    localparam logic [15:0] LEN_EXPECT = 16'(PAYLOAD_LENGTH);

    logic [7:0]  pos_reg, pos_next;
    logic [15:0] crc_reg, crc_next, crc_upd;
    logic [7:0]  crc_lo_reg, crc_lo_next, crc_lo_upd;
    logic [7:0]  addr_reg, addr_next, addr_upd;
    logic [7:0]  func_reg, func_next, func_upd;
    logic [15:0] len_reg, len_next, len_upd;
    logic [7:0]  rate_reg, rate_next, rate_upd;
    logic [7:0]  count_reg, count_next, count_upd;

    logic [7:0]  line_bytes_reg [LINE_BYTES];
    logic [24:0] energy_reg;
    logic [31:0] prod_reg;
    logic [28:0] quot_reg;
    logic [63:0] recip_prod;

    logic [7:0]  off;
    logic [3:0]  j;
    logic        in_lines;
    logic        in_temp;
    logic        line_done;
    status_t     status;
    rec_t        data_rec;
    rec_t        verdict_rec;

    assign off       = pos_reg - HEAD_POS;
    assign j         = off[3:0];
    assign in_lines  = (pos_reg >= HEAD_POS) && (pos_reg < RATE_POS);
    assign in_temp   = (pos_reg > RATE_POS) && (pos_reg < COUNT_POS);
    assign line_done = in_lines && (j == 4'd15);
    assign recip_prod = {32'h0, prod_reg} * {32'h0, DIV10_RECIP};

    // header, rate, count, crc and position updates
    always_comb
    begin
        crc_upd   = (pos_reg < CRC_LO_POS) ? crc16_feed(crc_reg, rx_byte) : crc_reg;
        crc_lo_upd = (pos_reg == CRC_LO_POS) ? rx_byte : crc_lo_reg;
        addr_upd  = (pos_reg == 8'd0) ? rx_byte : addr_reg;
        func_upd  = (pos_reg == 8'd1) ? rx_byte : func_reg;
        len_upd   = len_reg;
        if (pos_reg == 8'd2)
        begin
            len_upd[15:8] = rx_byte;
        end
        if (pos_reg == 8'd3)
        begin
            len_upd[7:0] = rx_byte;
        end
        rate_upd  = (pos_reg == RATE_POS) ? rx_byte : rate_reg;
        count_upd = (pos_reg == COUNT_POS) ? rx_byte : count_reg;

        pos_next    = pos_reg;
        crc_next    = crc_reg;
        crc_lo_next = crc_lo_reg;
        addr_next   = addr_reg;
        func_next   = func_reg;
        len_next    = len_reg;
        rate_next   = rate_reg;
        count_next  = count_reg;
        if (accept)
        begin
            if (frame_end)
            begin
                pos_next    = 8'd0;
                crc_next    = CRC_INIT;
                crc_lo_next = 8'd0;
                addr_next   = 8'd0;
                func_next   = 8'd0;
                len_next    = 16'd0;
                rate_next   = 8'd0;
                count_next  = 8'd0;
            end
            else
            begin
                pos_next    = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + 8'd1;
                crc_next    = crc_upd;
                crc_lo_next = crc_lo_upd;
                addr_next   = addr_upd;
                func_next   = func_upd;
                len_next    = len_upd;
                rate_next   = rate_upd;
                count_next  = count_upd;
            end
        end
    end

    // verdict
    always_comb
    begin
        priority if (pos_reg < LAST_POS)
        begin
            status = STATUS_SHORT;
        end
        else if (pos_reg > LAST_POS)
        begin
            status = STATUS_LONG;
        end
        else if (len_reg != LEN_EXPECT)
        begin
            status = STATUS_LEN;
        end
        else if ({rx_byte, crc_lo_reg} != crc_reg)
        begin
            status = STATUS_CRC;
        end
        else
        begin
            status = STATUS_OK;
        end
    end

    // record build
    always_comb
    begin
        data_rec = '0;
        if (in_temp)
        begin
            data_rec.kind  = KIND_TEMP;
            data_rec.index = 3'(pos_reg - RATE_POS - 8'd1);
            data_rec.voltage_or_address = {8'h00, rx_byte};
        end
        else
        begin
            data_rec.kind  = KIND_LINE;
            data_rec.index = off[6:4];
            data_rec.voltage_or_address  = {line_bytes_reg[0], line_bytes_reg[1]};
            data_rec.current_or_function = {line_bytes_reg[2], line_bytes_reg[3]};
            data_rec.power_or_rate       = {line_bytes_reg[4], line_bytes_reg[5]};
            data_rec.energy              = energy_reg;
            data_rec.alarm_current       = {line_bytes_reg[10], line_bytes_reg[11]};
            data_rec.power_factor        = line_bytes_reg[12];
            data_rec.switch_state        = line_bytes_reg[13];
            data_rec.harmonic            = {line_bytes_reg[14], rx_byte};
            data_rec.apparent_power      = quot_reg;
        end

        verdict_rec = '0;
        verdict_rec.kind                = KIND_VERDICT;
        verdict_rec.voltage_or_address  = {8'h00, addr_upd};
        verdict_rec.current_or_function = {8'h00, func_upd};
        verdict_rec.power_or_rate       = {8'h00, rate_upd};
        verdict_rec.alarm_current       = {8'h00, count_upd};
        verdict_rec.status              = status;

        push = '0;
        rec0 = verdict_rec;
        rec1 = verdict_rec;
        if (accept)
        begin
            if (line_done || in_temp)
            begin
                rec0        = data_rec;
                push.first  = 1'b1;
                push.second = frame_end;
            end
            else
            begin
                push.first = frame_end;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 8'd0;
            crc_reg    <= CRC_INIT;
            crc_lo_reg <= 8'd0;
            addr_reg   <= 8'd0;
            func_reg   <= 8'd0;
            len_reg    <= 16'd0;
            rate_reg   <= 8'd0;
            count_reg  <= 8'd0;
        end
        else
        begin
            pos_reg    <= pos_next;
            crc_reg    <= crc_next;
            crc_lo_reg <= crc_lo_next;
            addr_reg   <= addr_next;
            func_reg   <= func_next;
            len_reg    <= len_next;
            rate_reg   <= rate_next;
            count_reg  <= count_next;
        end
    end

    // line assembly; product after current, quotient one byte later
    always_ff @(posedge clk)
    begin
        if (accept && in_lines)
        begin
            line_bytes_reg[j] <= rx_byte;
            if (j == 4'd3)
            begin
                prod_reg <= {line_bytes_reg[0], line_bytes_reg[1]}
                          * {line_bytes_reg[2], rx_byte};
            end
            if (j == 4'd4)
            begin
                quot_reg <= 29'(recip_prod >> DIV10_SHIFT);
            end
            if (j == 4'd7)
            begin
                energy_reg <= {1'b0, line_bytes_reg[6], rx_byte, 8'h00};
            end
            if (j == 4'd9)
            begin
                energy_reg <= energy_reg + {9'h000, line_bytes_reg[8], rx_byte};
            end
        end
    end

endmodule

// ===== src/mfp_rec_fifo.sv =====
// record queue: takes up to two records per beat, hands out one
// depends on mfp_pkg
module mfp_rec_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  mfp_pkg::push_t push,
    input  mfp_pkg::rec_t  rec0,
    input  mfp_pkg::rec_t  rec1,
    input  logic           pop,
    output mfp_pkg::rec_t  head,
    output logic           not_empty,
    output logic           has_room
);
    import mfp_pkg::*;

    localparam int DEPTH = REC_FIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    rec_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] n_push;

    assign n_push    = CNT_W'(push.first) + CNT_W'(push.second);
    assign head      = mem[rd_ptr_reg];
    assign not_empty = (cnt_reg != '0);
    assign has_room  = (cnt_reg <= CNT_W'(DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(n_push);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        cnt_next    = cnt_reg + n_push - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.first)
        begin
            mem[wr_ptr_reg] <= rec0;
        end
        if (push.second)
        begin
            mem[wr_ptr_reg + PTR_W'(1)] <= rec1;
        end
    end

endmodule

// ===== src/meter_frame_parser_unit.sv =====
// meter frame parser top level: byte channel in, record channel out
// depends on mfp_pkg, mfp_byte_if, mfp_rec_if, mfp_core, mfp_rec_fifo
//
//   channel  | dir | beat
//   ---------+-----+--------------------------------------------------
//   in_ch    | in  | one frame byte, frame_end on the last byte
//   out_ch   | out | one line, temperature or verdict record
//
// one byte is taken each cycle the queue has room; its records are written
// to a four-entry record queue in the same cycle and can leave on the next one
// a byte yields at most two records; in_ch.ready is low while fewer than two
// queue entries are free, so a sustained output stall stops input
// reset clears position, crc, header fields and the queue; no clearing pass
module meter_frame_parser_unit #(
    parameter int LINE_COUNT     = mfp_pkg::DEF_LINE_COUNT,
    parameter int SENSOR_COUNT   = mfp_pkg::DEF_SENSOR_COUNT,
    parameter int PAYLOAD_LENGTH = mfp_pkg::DEF_PAYLOAD_LENGTH
) (
    input logic      clk,
    input logic      rst_n,
    mfp_byte_if.sink in_ch,
    mfp_rec_if.source out_ch
);
    import mfp_pkg::*;

    logic  accept;
    logic  pop;
    logic  not_empty;
    logic  has_room;
    push_t push;
    rec_t  rec0;
    rec_t  rec1;
    rec_t  head;

    assign in_ch.ready = has_room;
    assign accept      = in_ch.valid & has_room;
    assign pop         = not_empty & out_ch.ready;

    mfp_core #(
        .LINE_COUNT     (LINE_COUNT),
        .SENSOR_COUNT   (SENSOR_COUNT),
        .PAYLOAD_LENGTH (PAYLOAD_LENGTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (in_ch.rx_byte),
        .frame_end (in_ch.frame_end),
        .rec0      (rec0),
        .rec1      (rec1),
        .push      (push)
    );

    mfp_rec_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .rec0      (rec0),
        .rec1      (rec1),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .has_room  (has_room)
    );

    assign out_ch.valid               = not_empty;
    assign out_ch.record_kind         = 2'(head.kind);
    assign out_ch.record_index        = head.index;
    assign out_ch.voltage_or_address  = head.voltage_or_address;
    assign out_ch.current_or_function = head.current_or_function;
    assign out_ch.power_or_rate       = head.power_or_rate;
    assign out_ch.energy              = head.energy;
    assign out_ch.alarm_current       = head.alarm_current;
    assign out_ch.power_factor        = head.power_factor;
    assign out_ch.switch_state        = head.switch_state;
    assign out_ch.harmonic            = head.harmonic;
    assign out_ch.apparent_power      = head.apparent_power;
    assign out_ch.frame_status        = 3'(head.status);

endmodule

// ===== src/mfp_checker.sv =====
// port checks for the meter frame parser, bound to the top level
// depends on mfp_pkg and meter_frame_parser_unit
module mfp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  kind,
    input logic [2:0]  index,
    input logic [15:0] voa,
    input logic [15:0] cof,
    input logic [24:0] energy,
    input logic [28:0] apparent,
    input logic [2:0]  status
);
    import mfp_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(status)
                                    && $stable(voa) && $stable(index))
        else $error("record beat changed while stalled");

    a_verdict_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_VERDICT |-> index == 3'd0 && energy == 25'd0
                                              && apparent == 29'd0)
        else $error("verdict carries line fields");

    a_record_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_VERDICT |-> status == STATUS_OK)
        else $error("status on a non-verdict record");

    a_temp_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_TEMP |-> cof == 16'd0 && voa[15:8] == 8'd0
                                           && energy == 25'd0)
        else $error("temperature record has stray fields");

endmodule

bind meter_frame_parser_unit mfp_checker u_mfp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .kind      (out_ch.record_kind),
    .index     (out_ch.record_index),
    .voa       (out_ch.voltage_or_address),
    .cof       (out_ch.current_or_function),
    .energy    (out_ch.energy),
    .apparent  (out_ch.apparent_power),
    .status    (out_ch.frame_status)
);
